>>> sv/tmac_pkg.sv
// shared constants, register indexes and control store for the touch filter
package tmac_pkg;

  localparam int BURST_LEN_DEF    = 7;
  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int MAX_AVERAGES_DEF = 16;

  localparam int CFG_W  = 12;
  localparam int NAVG_W = 5;
  localparam int POS_W  = 13;
  localparam int IDX_W  = 3;

  localparam logic [NAVG_W-1:0] NAVG_RESET = NAVG_W'(5);
  localparam logic [CFG_W-1:0]  XOFF_RESET = CFG_W'(255);
  localparam logic [CFG_W-1:0]  YOFF_RESET = CFG_W'(200);
  localparam logic [CFG_W-1:0]  XDIV_RESET = CFG_W'(11);
  localparam logic [CFG_W-1:0]  YDIV_RESET = CFG_W'(14);

  localparam logic [IDX_W-1:0] REG_NUM_AVERAGES = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_X_OFFSET     = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_Y_OFFSET     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_X_DIVISOR    = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_Y_DIVISOR    = IDX_W'(4);

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_IDLE   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_RANK   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_ACC    = OP_W'(2);
  localparam logic [OP_W-1:0] OP_DLOAD  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_DSTORE = OP_W'(4);
  localparam logic [OP_W-1:0] OP_EMIT   = OP_W'(5);

  localparam int CND_W = 3;
  localparam logic [CND_W-1:0] C_NEXT       = CND_W'(0);
  localparam logic [CND_W-1:0] C_GOTO       = CND_W'(1);
  localparam logic [CND_W-1:0] C_HOLD_IDLE  = CND_W'(2);
  localparam logic [CND_W-1:0] C_HOLD_RANK  = CND_W'(3);
  localparam logic [CND_W-1:0] C_SKIP_FRAME = CND_W'(4);
  localparam logic [CND_W-1:0] C_HOLD_DIV   = CND_W'(5);

  localparam int DS_W = 2;
  localparam logic [DS_W-1:0] DS_XAVG = DS_W'(0);
  localparam logic [DS_W-1:0] DS_YAVG = DS_W'(1);
  localparam logic [DS_W-1:0] DS_XCAL = DS_W'(2);
  localparam logic [DS_W-1:0] DS_YCAL = DS_W'(3);

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_IDLE    = PC_W'(0);
  localparam logic [PC_W-1:0] ST_RANK    = PC_W'(1);
  localparam logic [PC_W-1:0] ST_ACC     = PC_W'(2);
  localparam logic [PC_W-1:0] ST_XAVG_LD = PC_W'(3);
  localparam logic [PC_W-1:0] ST_XAVG_WT = PC_W'(4);
  localparam logic [PC_W-1:0] ST_YAVG_LD = PC_W'(5);
  localparam logic [PC_W-1:0] ST_YAVG_WT = PC_W'(6);
  localparam logic [PC_W-1:0] ST_XCAL_LD = PC_W'(7);
  localparam logic [PC_W-1:0] ST_XCAL_WT = PC_W'(8);
  localparam logic [PC_W-1:0] ST_YCAL_LD = PC_W'(9);
  localparam logic [PC_W-1:0] ST_YCAL_WT = PC_W'(10);
  localparam logic [PC_W-1:0] ST_EMIT    = PC_W'(11);

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cnd;
    logic [DS_W-1:0]  dsel;
    logic [PC_W-1:0]  target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      ST_IDLE:    w = '{OP_IDLE,   C_HOLD_IDLE,  DS_XAVG, ST_IDLE};
      ST_RANK:    w = '{OP_RANK,   C_HOLD_RANK,  DS_XAVG, ST_RANK};
      ST_ACC:     w = '{OP_ACC,    C_SKIP_FRAME, DS_XAVG, ST_IDLE};
      ST_XAVG_LD: w = '{OP_DLOAD,  C_NEXT,       DS_XAVG, ST_IDLE};
      ST_XAVG_WT: w = '{OP_DSTORE, C_HOLD_DIV,   DS_XAVG, ST_XAVG_WT};
      ST_YAVG_LD: w = '{OP_DLOAD,  C_NEXT,       DS_YAVG, ST_IDLE};
      ST_YAVG_WT: w = '{OP_DSTORE, C_HOLD_DIV,   DS_YAVG, ST_YAVG_WT};
      ST_XCAL_LD: w = '{OP_DLOAD,  C_NEXT,       DS_XCAL, ST_IDLE};
      ST_XCAL_WT: w = '{OP_DSTORE, C_HOLD_DIV,   DS_XCAL, ST_XCAL_WT};
      ST_YCAL_LD: w = '{OP_DLOAD,  C_NEXT,       DS_YCAL, ST_IDLE};
      ST_YCAL_WT: w = '{OP_DSTORE, C_HOLD_DIV,   DS_YCAL, ST_YCAL_WT};
      ST_EMIT:    w = '{OP_EMIT,   C_GOTO,       DS_XAVG, ST_IDLE};
      default:    w = '{OP_IDLE,   C_GOTO,       DS_XAVG, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/tmac_div.sv
// restoring unsigned divider, one quotient bit per cycle
module tmac_div #(
  parameter int DVD_W = 16,
  parameter int DVS_W = tmac_pkg::CFG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             busy
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem, quo[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

endmodule

>>> sv/touch_median_average_calibrate.sv
// touch filter top: burst store, median ranking, averaging, calibration, control store
//
//  channel   handshake           fields
//  -------   -----------------   --------------------------------
//  sample    start / busy        x_sample, y_sample, pen_down
//  result    done (one cycle)    x_pos, y_pos, valid_res
//  config    cfg_we              cfg_index, cfg_data
//
// a sample beat inside a burst is only stored in the burst buffer; busy stays low
// the last beat of a burst holds busy through ranking (ST_RANK) and summing (ST_ACC),
// and at the end of a frame also through four divisions on one shared divider and ST_EMIT
// rst is synchronous and clears control state and config registers to their defaults
// results cannot be stalled: done marks each result for exactly one cycle
module touch_median_average_calibrate #(
  parameter int BURST_LEN    = tmac_pkg::BURST_LEN_DEF,
  parameter int SAMPLE_BITS  = tmac_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_AVERAGES = tmac_pkg::MAX_AVERAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [SAMPLE_BITS-1:0]              x_sample,
  input  logic [SAMPLE_BITS-1:0]              y_sample,
  input  logic                                pen_down,
  output logic                                done,
  output logic signed [tmac_pkg::POS_W-1:0]   x_pos,
  output logic signed [tmac_pkg::POS_W-1:0]   y_pos,
  output logic                                valid_res,
  input  logic                                cfg_we,
  input  logic [tmac_pkg::IDX_W-1:0]          cfg_index,
  input  logic [tmac_pkg::CFG_W-1:0]          cfg_data
);

  localparam int SIDX_W = $clog2(BURST_LEN);
  localparam int RANK_W = $clog2(BURST_LEN + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_AVERAGES);
  localparam int BIDX_W = $clog2(MAX_AVERAGES + 1);
  localparam int MAG_W  = (SUM_W > tmac_pkg::CFG_W) ? SUM_W : tmac_pkg::CFG_W;
  localparam int DIFF_W = MAG_W + 1;
  localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(BURST_LEN - 1);
  localparam logic [RANK_W-1:0] MED_RANK = RANK_W'((BURST_LEN - 1) / 2);

  // config registers
  logic [tmac_pkg::NAVG_W-1:0] num_averages;
  logic [tmac_pkg::CFG_W-1:0]  x_offset;
  logic [tmac_pkg::CFG_W-1:0]  y_offset;
  logic [tmac_pkg::CFG_W-1:0]  x_divisor;
  logic [tmac_pkg::CFG_W-1:0]  y_divisor;

  // sequencer and datapath
  logic [tmac_pkg::PC_W-1:0] pc;
  logic [tmac_pkg::PC_W-1:0] pc_next;
  tmac_pkg::uword_t          uw;
  logic                      take;

  logic [SAMPLE_BITS-1:0] xb [BURST_LEN];
  logic [SAMPLE_BITS-1:0] yb [BURST_LEN];
  logic [SIDX_W-1:0]      sample_index;
  logic [SIDX_W-1:0]      cand;
  logic [BIDX_W-1:0]      burst_index;
  logic [SUM_W-1:0]       x_sum;
  logic [SUM_W-1:0]       y_sum;
  logic                   burst_counts;
  logic                   any_counted;
  logic [SAMPLE_BITS-1:0] med_x;
  logic [SAMPLE_BITS-1:0] med_y;
  logic [SUM_W-1:0]       xa;
  logic [SUM_W-1:0]       ya;
  logic                   cal_neg;
  logic signed [tmac_pkg::POS_W-1:0] x_cal;
  logic signed [tmac_pkg::POS_W-1:0] y_cal;

  logic                   accept;
  logic                   last_sample;
  logic [SAMPLE_BITS-1:0] xc;
  logic [SAMPLE_BITS-1:0] yc;
  logic [RANK_W-1:0]      rank_x;
  logic [RANK_W-1:0]      rank_y;
  logic [BIDX_W-1:0]      n_eff;
  logic [BIDX_W-1:0]      bnext;
  logic                   frame_end;
  logic [DIFF_W-1:0]      diff_x;
  logic [DIFF_W-1:0]      diff_y;
  logic [DIFF_W-1:0]      mag_x;
  logic [DIFF_W-1:0]      mag_y;
  logic                   div_load;
  logic [MAG_W-1:0]       div_dvd;
  logic [tmac_pkg::CFG_W-1:0] div_dvs;
  logic [MAG_W-1:0]       div_quo;
  logic                   div_busy;
  logic [MAG_W:0]         signed_quo;

  assign busy        = pc != tmac_pkg::ST_IDLE;
  assign accept      = start && !busy;
  assign last_sample = sample_index == LAST_IDX;
  assign uw          = tmac_pkg::ucode(pc);

  // stable rank of the candidate: smaller entries plus equal ones placed ahead of it
  always_comb begin
    xc     = xb[cand];
    yc     = yb[cand];
    rank_x = '0;
    rank_y = '0;
    for (int j = 0; j < BURST_LEN; j++) begin
      rank_x = rank_x + RANK_W'((xb[j] < xc) || ((xb[j] == xc) && (SIDX_W'(j) < cand)));
      rank_y = rank_y + RANK_W'((yb[j] < yc) || ((yb[j] == yc) && (SIDX_W'(j) < cand)));
    end
  end

  always_comb begin
    if (num_averages == '0) begin
      n_eff = BIDX_W'(1);
    end else if (num_averages > MAX_AVERAGES) begin
      n_eff = BIDX_W'(MAX_AVERAGES);
    end else begin
      n_eff = BIDX_W'(num_averages);
    end
    bnext     = burst_index + BIDX_W'(1);
    frame_end = bnext >= n_eff;
  end

  always_comb begin
    diff_x = DIFF_W'(xa) - DIFF_W'(x_offset);
    diff_y = DIFF_W'(ya) - DIFF_W'(y_offset);
    mag_x  = diff_x[DIFF_W-1] ? -diff_x : diff_x;
    mag_y  = diff_y[DIFF_W-1] ? -diff_y : diff_y;
    case (uw.dsel)
      tmac_pkg::DS_XAVG: begin
        div_dvd = MAG_W'(x_sum);
        div_dvs = tmac_pkg::CFG_W'(n_eff);
      end
      tmac_pkg::DS_YAVG: begin
        div_dvd = MAG_W'(y_sum);
        div_dvs = tmac_pkg::CFG_W'(n_eff);
      end
      tmac_pkg::DS_XCAL: begin
        div_dvd = mag_x[MAG_W-1:0];
        div_dvs = (x_divisor == '0) ? tmac_pkg::CFG_W'(1) : x_divisor;
      end
      default: begin
        div_dvd = mag_y[MAG_W-1:0];
        div_dvs = (y_divisor == '0) ? tmac_pkg::CFG_W'(1) : y_divisor;
      end
    endcase
    div_load   = uw.op == tmac_pkg::OP_DLOAD;
    signed_quo = cal_neg ? -{1'b0, div_quo} : {1'b0, div_quo};
  end

  tmac_div #(
    .DVD_W (MAG_W),
    .DVS_W (tmac_pkg::CFG_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  always_comb begin
    unique case (uw.cnd)
      tmac_pkg::C_NEXT:       take = 1'b0;
      tmac_pkg::C_GOTO:       take = 1'b1;
      tmac_pkg::C_HOLD_IDLE:  take = !(accept && last_sample);
      tmac_pkg::C_HOLD_RANK:  take = cand != LAST_IDX;
      tmac_pkg::C_SKIP_FRAME: take = !frame_end;
      tmac_pkg::C_HOLD_DIV:   take = div_busy;
      default:                take = 1'b1;
    endcase
    pc_next = take ? uw.target : pc + tmac_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_averages <= tmac_pkg::NAVG_RESET;
      x_offset     <= tmac_pkg::XOFF_RESET;
      y_offset     <= tmac_pkg::YOFF_RESET;
      x_divisor    <= tmac_pkg::XDIV_RESET;
      y_divisor    <= tmac_pkg::YDIV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmac_pkg::REG_NUM_AVERAGES: num_averages <= cfg_data[tmac_pkg::NAVG_W-1:0];
        tmac_pkg::REG_X_OFFSET:     x_offset     <= cfg_data;
        tmac_pkg::REG_Y_OFFSET:     y_offset     <= cfg_data;
        tmac_pkg::REG_X_DIVISOR:    x_divisor    <= cfg_data;
        tmac_pkg::REG_Y_DIVISOR:    y_divisor    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= tmac_pkg::ST_IDLE;
      sample_index <= '0;
      cand         <= '0;
      burst_index  <= '0;
      x_sum        <= '0;
      y_sum        <= '0;
      burst_counts <= 1'b0;
      any_counted  <= 1'b0;
      done         <= 1'b0;
    end else begin
      pc   <= pc_next;
      done <= uw.op == tmac_pkg::OP_EMIT;
      unique case (uw.op)
        tmac_pkg::OP_IDLE: begin
          if (accept) begin
            xb[sample_index] <= x_sample;
            yb[sample_index] <= y_sample;
            if (sample_index == '0) begin
              burst_counts <= pen_down;
            end
            sample_index <= last_sample ? '0 : sample_index + SIDX_W'(1);
          end
        end
        tmac_pkg::OP_RANK: begin
          if (rank_x == MED_RANK) begin
            med_x <= xc;
          end
          if (rank_y == MED_RANK) begin
            med_y <= yc;
          end
          cand <= (cand == LAST_IDX) ? '0 : cand + SIDX_W'(1);
        end
        tmac_pkg::OP_ACC: begin
          if (burst_counts) begin
            x_sum       <= x_sum + SUM_W'(med_x);
            y_sum       <= y_sum + SUM_W'(med_y);
            any_counted <= 1'b1;
          end
          burst_index <= frame_end ? '0 : bnext;
        end
        tmac_pkg::OP_DLOAD: begin
          if (uw.dsel == tmac_pkg::DS_XCAL) begin
            cal_neg <= diff_x[DIFF_W-1];
          end else if (uw.dsel == tmac_pkg::DS_YCAL) begin
            cal_neg <= diff_y[DIFF_W-1];
          end
        end
        tmac_pkg::OP_DSTORE: begin
          if (!div_busy) begin
            case (uw.dsel)
              tmac_pkg::DS_XAVG: xa    <= div_quo[SUM_W-1:0];
              tmac_pkg::DS_YAVG: ya    <= div_quo[SUM_W-1:0];
              tmac_pkg::DS_XCAL: x_cal <= signed_quo[tmac_pkg::POS_W-1:0];
              default:           y_cal <= signed_quo[tmac_pkg::POS_W-1:0];
            endcase
          end
        end
        tmac_pkg::OP_EMIT: begin
          valid_res   <= any_counted;
          x_pos       <= any_counted ? x_cal : '0;
          y_pos       <= any_counted ? y_cal : '0;
          x_sum       <= '0;
          y_sum       <= '0;
          any_counted <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_no_burst_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (x_pos == '0 && y_pos == '0))
    else $error("result without counted burst is not zero");

  a_last_beat_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && sample_index == LAST_IDX) |=> busy)
    else $error("last beat of burst did not start processing");

  a_busy_burst_start: assert property (@(posedge clk) disable iff (rst)
    busy |-> (sample_index == '0))
    else $error("processing while a burst is partly filled");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !div_busy)
    else $error("divider running while sequencer is idle");

endmodule

>>> tb/touch_median_average_calibrate_test.sv
// self-checking testbench for the touch median/average/calibrate filter
`timescale 1ns / 1ps

module touch_median_average_calibrate_test;

  localparam int SAMPLE_MAX    = (1 << tmac_pkg::SAMPLE_BITS_DEF) - 1;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int SETTLE_CYCLES = 120;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [tmac_pkg::IDX_W-1:0] REG_SPARE_FIRST =
    tmac_pkg::REG_Y_DIVISOR + tmac_pkg::IDX_W'(1);

  typedef logic [tmac_pkg::SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct packed {
    logic signed [tmac_pkg::POS_W-1:0] x_pos;
    logic signed [tmac_pkg::POS_W-1:0] y_pos;
    logic                              valid;
  } coord_t;

  typedef enum logic {ROW_CFG, ROW_BURST} row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    logic [tmac_pkg::IDX_W-1:0]        idx;
    logic [tmac_pkg::CFG_W-1:0]        data;
    sample_t                           x;
    sample_t                           y;
    logic                              pen;
    bit                                checked;
    logic signed [tmac_pkg::POS_W-1:0] want_x;
    logic signed [tmac_pkg::POS_W-1:0] want_y;
    logic                              want_valid;
  } plan_row_t;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  sample_t                           x_sample;
  sample_t                           y_sample;
  logic                              pen_down;
  logic                              done;
  logic signed [tmac_pkg::POS_W-1:0] x_pos;
  logic signed [tmac_pkg::POS_W-1:0] y_pos;
  logic                              valid_res;
  logic                              cfg_we;
  logic [tmac_pkg::IDX_W-1:0]        cfg_index;
  logic [tmac_pkg::CFG_W-1:0]        cfg_data;

  // filter state mirrored for prediction
  sample_t     burst_x [tmac_pkg::BURST_LEN_DEF];
  sample_t     burst_y [tmac_pkg::BURST_LEN_DEF];
  int          slot;
  int          bursts_taken;
  int          sum_x;
  int          sum_y;
  bit          burst_live;
  bit          frame_live;
  int          avg_count;
  int          off_x;
  int          off_y;
  int          div_x;
  int          div_y;

  coord_t      pending_coords [$];
  coord_t      pinned;
  bit          pin_armed;
  int          mismatches;
  int          strays;
  int          results_seen;
  int          beats_sent;
  int          cfg_writes;
  int          run_left;
  int          burst_pos;

  plan_row_t directed_plan [9] = '{
    '{ROW_BURST, tmac_pkg::REG_NUM_AVERAGES, '0, 12'd0, 12'd0, 1'b0, 1'b0,
      '0, '0, 1'b0},
    '{ROW_CFG, tmac_pkg::REG_NUM_AVERAGES, 12'd1, '0, '0, 1'b0, 1'b0,
      '0, '0, 1'b0},
    '{ROW_BURST, tmac_pkg::REG_NUM_AVERAGES, '0, 12'd4095, 12'd4095, 1'b0, 1'b1,
      13'sd0, 13'sd0, 1'b0},
    '{ROW_BURST, tmac_pkg::REG_NUM_AVERAGES, '0, 12'd4095, 12'd4095, 1'b1, 1'b1,
      13'sd349, 13'sd278, 1'b1},
    '{ROW_CFG, tmac_pkg::REG_X_OFFSET, 12'd4095, '0, '0, 1'b0, 1'b0,
      '0, '0, 1'b0},
    '{ROW_CFG, tmac_pkg::REG_Y_OFFSET, 12'd4095, '0, '0, 1'b0, 1'b0,
      '0, '0, 1'b0},
    '{ROW_CFG, tmac_pkg::REG_X_DIVISOR, 12'd0, '0, '0, 1'b0, 1'b0,
      '0, '0, 1'b0},
    '{ROW_CFG, tmac_pkg::REG_Y_DIVISOR, 12'd4095, '0, '0, 1'b0, 1'b0,
      '0, '0, 1'b0},
    '{ROW_BURST, tmac_pkg::REG_NUM_AVERAGES, '0, 12'd0, 12'd0, 1'b1, 1'b1,
      -13'sd4095, -13'sd1, 1'b1}
  };

  touch_median_average_calibrate i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .x_sample  (x_sample),
    .y_sample  (y_sample),
    .pen_down  (pen_down),
    .done      (done),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .valid_res (valid_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout: %0d results still due", pending_coords.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic sample_t middle_value(input sample_t v [tmac_pkg::BURST_LEN_DEF]);
    sample_t t [tmac_pkg::BURST_LEN_DEF];
    sample_t k;
    t = v;
    for (int i = 0; i < tmac_pkg::BURST_LEN_DEF - 1; i++) begin
      for (int j = 0; j < tmac_pkg::BURST_LEN_DEF - 1 - i; j++) begin
        if (t[j] > t[j+1]) begin
          k = t[j];
          t[j] = t[j+1];
          t[j+1] = k;
        end
      end
    end
    return t[(tmac_pkg::BURST_LEN_DEF - 1) / 2];
  endfunction

  function automatic logic signed [tmac_pkg::POS_W-1:0] scale_axis(input int avg,
                                                                   input int off,
                                                                   input int dv);
    int q;
    q = (avg - off) / ((dv == 0) ? 1 : dv);
    return q[tmac_pkg::POS_W-1:0];
  endfunction

  task automatic clear_filter();
    for (int i = 0; i < tmac_pkg::BURST_LEN_DEF; i++) begin
      burst_x[i] = '0;
      burst_y[i] = '0;
    end
    slot = 0;
    bursts_taken = 0;
    sum_x = 0;
    sum_y = 0;
    burst_live = 1'b0;
    frame_live = 1'b0;
    avg_count = int'(tmac_pkg::NAVG_RESET);
    off_x = int'(tmac_pkg::XOFF_RESET);
    off_y = int'(tmac_pkg::YOFF_RESET);
    div_x = int'(tmac_pkg::XDIV_RESET);
    div_y = int'(tmac_pkg::YDIV_RESET);
  endtask

  task automatic advance_filter(input sample_t xs, input sample_t ys, input logic pen,
                                output bit made, output coord_t r);
    int n;
    made = 1'b0;
    r = '0;
    if (slot == 0) burst_live = pen;
    burst_x[slot] = xs;
    burst_y[slot] = ys;
    if (slot < tmac_pkg::BURST_LEN_DEF - 1) begin
      slot++;
      return;
    end
    slot = 0;
    if (burst_live) begin
      sum_x += int'(middle_value(burst_x));
      sum_y += int'(middle_value(burst_y));
      frame_live = 1'b1;
    end
    bursts_taken++;
    n = (avg_count == 0) ? 1 :
        ((avg_count > tmac_pkg::MAX_AVERAGES_DEF) ? tmac_pkg::MAX_AVERAGES_DEF : avg_count);
    if (bursts_taken < n) return;
    made = 1'b1;
    if (frame_live) begin
      r.x_pos = scale_axis(sum_x / n, off_x, div_x);
      r.y_pos = scale_axis(sum_y / n, off_y, div_y);
      r.valid = 1'b1;
    end
    sum_x = 0;
    sum_y = 0;
    bursts_taken = 0;
    frame_live = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    coord_t got;
    coord_t want;
    coord_t pred;
    bit     made;
    if (!rst) begin
      if (done) begin
        got = '{x_pos, y_pos, valid_res};
        results_seen++;
        if (pending_coords.size() == 0) begin
          strays++;
          if (mismatches + strays <= REPORT_LIMIT)
            $display("%0t: unexpected result x=%0d y=%0d valid=%0b", $realtime,
                     got.x_pos, got.y_pos, got.valid);
        end else begin
          want = pending_coords.pop_front();
          if (got.x_pos !== want.x_pos || got.y_pos !== want.y_pos ||
              got.valid !== want.valid) begin
            mismatches++;
            if (mismatches + strays <= REPORT_LIMIT)
              $display("%0t: result x=%0d y=%0d valid=%0b, expected x=%0d y=%0d valid=%0b",
                       $realtime, got.x_pos, got.y_pos, got.valid,
                       want.x_pos, want.y_pos, want.valid);
          end
        end
      end
      if (start && !busy) begin
        advance_filter(x_sample, y_sample, pen_down, made, pred);
        if (made) begin
          // a directed row with its result typed in takes the place of the prediction
          if (pin_armed) begin
            pred = pinned;
            pin_armed = 1'b0;
          end
          pending_coords.push_back(pred);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          tmac_pkg::REG_NUM_AVERAGES: avg_count = int'(cfg_data[tmac_pkg::NAVG_W-1:0]);
          tmac_pkg::REG_X_OFFSET:     off_x = int'(cfg_data);
          tmac_pkg::REG_Y_OFFSET:     off_y = int'(cfg_data);
          tmac_pkg::REG_X_DIVISOR:    div_x = int'(cfg_data);
          tmac_pkg::REG_Y_DIVISOR:    div_y = int'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      x_sample = sample_t'($urandom);
      y_sample = sample_t'($urandom);
      pen_down = 1'($urandom);
    end
  endtask

  task automatic send_sample(input sample_t xs, input sample_t ys, input logic pen);
    if (run_left == 0) begin
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
      run_left = $urandom_range(1, 24);
    end
    run_left--;
    @(negedge clk);
    start = 1'b1;
    x_sample = xs;
    y_sample = ys;
    pen_down = pen;
    do @(posedge clk); while (busy);
    beats_sent++;
    burst_pos = (burst_pos + 1) % tmac_pkg::BURST_LEN_DEF;
  endtask

  // block idle: all results in, and time for a burst end with no result to finish
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
    run_left = 0;
  endtask

  task automatic cfg_write(input logic [tmac_pkg::IDX_W-1:0] idx,
                           input logic [tmac_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_index = tmac_pkg::IDX_W'($urandom);
    cfg_data = tmac_pkg::CFG_W'($urandom);
    cfg_writes++;
  endtask

  task automatic shuffle_config();
    logic [tmac_pkg::CFG_W-1:0] w;
    if ($urandom_range(0, 1) == 0) begin
      w = tmac_pkg::CFG_W'($urandom);
      case ($urandom_range(0, 19))
        0:       w[tmac_pkg::NAVG_W-1:0] = '0;
        1:       w[tmac_pkg::NAVG_W-1:0] = tmac_pkg::NAVG_W'(tmac_pkg::MAX_AVERAGES_DEF);
        2:       w[tmac_pkg::NAVG_W-1:0] =
                   tmac_pkg::NAVG_W'($urandom_range(tmac_pkg::MAX_AVERAGES_DEF + 1, 31));
        3, 4:    w[tmac_pkg::NAVG_W-1:0] =
                   tmac_pkg::NAVG_W'($urandom_range(5, tmac_pkg::MAX_AVERAGES_DEF));
        default: w[tmac_pkg::NAVG_W-1:0] = tmac_pkg::NAVG_W'($urandom_range(1, 4));
      endcase
      cfg_write(tmac_pkg::REG_NUM_AVERAGES, w);
    end
    for (int a = 0; a < 2; a++) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       w = '0;
          1:       w = tmac_pkg::CFG_W'(SAMPLE_MAX);
          default: w = tmac_pkg::CFG_W'($urandom);
        endcase
        cfg_write((a == 0) ? tmac_pkg::REG_X_OFFSET : tmac_pkg::REG_Y_OFFSET, w);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0:       w = '0;
          1:       w = tmac_pkg::CFG_W'(SAMPLE_MAX);
          2, 3:    w = tmac_pkg::CFG_W'($urandom);
          default: w = tmac_pkg::CFG_W'($urandom_range(1, 32));
        endcase
        cfg_write((a == 0) ? tmac_pkg::REG_X_DIVISOR : tmac_pkg::REG_Y_DIVISOR, w);
      end
    end
    if ($urandom_range(0, 7) == 0)
      cfg_write(REG_SPARE_FIRST + tmac_pkg::IDX_W'($urandom_range(0, 2)),
                tmac_pkg::CFG_W'($urandom));
  endtask

  initial begin : stimulus
    int      mode;
    int      cx;
    int      cy;
    int      vx;
    int      vy;
    int      random_beats;
    int      phase_len;
    logic    pen_first;
    clear_filter();
    rst = 1'b1;
    start = 1'b0;
    x_sample = '0;
    y_sample = '0;
    pen_down = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin_armed = 1'b0;
    pinned = '0;
    mismatches = 0;
    strays = 0;
    results_seen = 0;
    beats_sent = 0;
    cfg_writes = 0;
    run_left = 0;
    burst_pos = 0;
    mode = 0;
    cx = 0;
    cy = 0;
    pen_first = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        settle();
        cfg_write(directed_plan[r].idx, directed_plan[r].data);
      end else begin
        for (int b = 0; b < tmac_pkg::BURST_LEN_DEF; b++) begin
          // only the first beat's pen flag counts; the rest carry the opposite
          if (b == tmac_pkg::BURST_LEN_DEF - 1 && directed_plan[r].checked) begin
            pinned = '{directed_plan[r].want_x, directed_plan[r].want_y,
                       directed_plan[r].want_valid};
            pin_armed = 1'b1;
          end
          send_sample(directed_plan[r].x, directed_plan[r].y,
                      (b == 0) ? directed_plan[r].pen : ~directed_plan[r].pen);
        end
      end
    end

    random_beats = 0;
    while (random_beats < RANDOM_ITEMS) begin
      settle();
      shuffle_config();
      phase_len = $urandom_range(5, 120);
      repeat (phase_len) begin
        if (burst_pos == 0) begin
          mode = $urandom_range(0, 3);
          cx = $urandom_range(0, SAMPLE_MAX);
          cy = $urandom_range(0, SAMPLE_MAX);
          pen_first = ($urandom_range(0, 6) != 0);
        end
        case (mode)
          0: begin
            vx = $urandom_range(0, SAMPLE_MAX);
            vy = $urandom_range(0, SAMPLE_MAX);
          end
          3: begin
            vx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, SAMPLE_MAX) :
                 (($urandom_range(0, 1) == 0) ? 0 : SAMPLE_MAX);
            vy = ($urandom_range(0, 2) == 0) ? $urandom_range(0, SAMPLE_MAX) :
                 (($urandom_range(0, 1) == 0) ? 0 : SAMPLE_MAX);
          end
          default: begin
            // tight cluster around a touch point, ties likely
            vx = cx + int'($urandom_range(0, 16)) - 8;
            vy = cy + int'($urandom_range(0, 16)) - 8;
            if (vx < 0) vx = 0;
            if (vx > SAMPLE_MAX) vx = SAMPLE_MAX;
            if (vy < 0) vy = 0;
            if (vy > SAMPLE_MAX) vy = SAMPLE_MAX;
          end
        endcase
        send_sample(sample_t'(vx), sample_t'(vy),
                    (burst_pos == 0) ? pen_first : 1'($urandom));
        random_beats++;
      end
    end

    settle();
    $display("covered %0d sample beats in bursts of %0d, %0d register writes",
             beats_sent, tmac_pkg::BURST_LEN_DEF, cfg_writes);
    $display("checked %0d coordinate results: %0d mismatched, %0d unexpected, %0d missing",
             results_seen, mismatches, strays, pending_coords.size());
    if (mismatches == 0 && strays == 0 && pending_coords.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
